@@ design/imu_complementary_orientation_unit_defines.svh @@
// Assertion macros shared by the orientation unit RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef IMU_COMPLEMENTARY_ORIENTATION_UNIT_DEFINES_SVH
`define IMU_COMPLEMENTARY_ORIENTATION_UNIT_DEFINES_SVH
// implication check under reset
`define ICO_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication check under reset
`define ICO_ASSERT_NXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ design/ico_pkg.sv @@
// Shared constants, types and the arctangent table for the orientation unit.
// Depends on nothing.
package ico_pkg;
	localparam int CordicSteps = 24;
	localparam int AtanEntries = 30;
	localparam int StepCnt = (CordicSteps < AtanEntries) ? CordicSteps : AtanEntries;
	localparam int SqrtSteps = 32;
	localparam logic signed [31:0] PiQ28 = 32'sd843314857;
	localparam logic [15:0] AlphaReset = 16'd64225;
	localparam logic [31:0] TickReset = 32'd4295;
	localparam logic [0:0] RegAlpha = 1'b0;
	localparam logic [0:0] RegTick = 1'b1;
	localparam logic ReqGyro = 1'b0;

	typedef struct packed {
		logic start;
		logic signed [47:0] y;
		logic signed [47:0] x;
	} cordic_req_t;

	function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
		logic signed [31:0] r;
		case (i)
			5'd0: r = 32'sd210828714;
			5'd1: r = 32'sd124459457;
			5'd2: r = 32'sd65760959;
			5'd3: r = 32'sd33381290;
			5'd4: r = 32'sd16755422;
			5'd5: r = 32'sd8385879;
			5'd6: r = 32'sd4193963;
			5'd7: r = 32'sd2097109;
			5'd8: r = 32'sd1048571;
			5'd9: r = 32'sd524287;
			5'd10: r = 32'sd262144;
			5'd11: r = 32'sd131072;
			5'd12: r = 32'sd65536;
			5'd13: r = 32'sd32768;
			5'd14: r = 32'sd16384;
			5'd15: r = 32'sd8192;
			5'd16: r = 32'sd4096;
			5'd17: r = 32'sd2048;
			5'd18: r = 32'sd1024;
			5'd19: r = 32'sd512;
			5'd20: r = 32'sd256;
			5'd21: r = 32'sd128;
			5'd22: r = 32'sd64;
			5'd23: r = 32'sd32;
			5'd24: r = 32'sd16;
			5'd25: r = 32'sd8;
			5'd26: r = 32'sd4;
			5'd27: r = 32'sd2;
			5'd28: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction
endpackage

@@ design/ico_cordic.sv @@
// Iterative CORDIC vectoring unit: atan2(y, x) in Q3.28, one step a cycle.
// Depends on ico_pkg.
module ico_cordic (
	input  logic clk,
	input  logic arst_n,
	input  ico_pkg::cordic_req_t req,
	output logic busy,
	output logic done,
	output logic signed [31:0] angle
);
	import ico_pkg::*;

	logic signed [49:0] x_q, y_q;
	logic signed [31:0] z_q;
	logic [4:0] step_q;
	logic busy_q, done_q;
	logic signed [49:0] xs, ys;
	logic signed [31:0] a;

	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign a = atan_q28(step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				step_q <= '0;
				if (req.x == 0 && req.y == 0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'(StepCnt - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			if (req.x < 0) begin
				x_q <= -50'(req.x);
				y_q <= -50'(req.y);
				z_q <= (req.y >= 0) ? PiQ28 : -PiQ28;
			end else begin
				x_q <= 50'(req.x);
				y_q <= 50'(req.y);
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + a;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - a;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign angle = z_q;

	`include "imu_complementary_orientation_unit_defines.svh"
	`ICO_ASSERT_IMP(a_no_start_busy, clk, arst_n, busy_q, !req.start)
	`ICO_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, !busy_q)
	`ICO_ASSERT_IMP(a_step_range, clk, arst_n, busy_q, step_q < 5'(StepCnt))
endmodule

@@ design/ico_isqrt.sv @@
// Iterative integer square root, one result bit a cycle.
// Depends on ico_pkg.
module ico_isqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [31:0] radicand,
	output logic done,
	output logic [31:0] root
);
	import ico_pkg::*;

	logic [63:0] rem_q;
	logic [31:0] root_q, src_q;
	logic [5:0] cnt_q;
	logic busy_q, done_q;
	logic [65:0] trial;
	logic [63:0] rem_sh;

	assign rem_sh = {rem_q[61:0], src_q[31:30]};
	assign trial = {2'b00, rem_sh} - {32'd0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(SqrtSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// radicand*2^32: 16 digit pairs from radicand, then zeros
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			root_q <= '0;
			src_q <= radicand;
		end else if (busy_q) begin
			src_q <= {src_q[29:0], 2'b00};
			if (!trial[65]) begin
				rem_q <= trial[63:0];
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

@@ design/imu_complementary_orientation_unit.sv @@
// Top level of the orientation unit: sequencer, state and shared multiplier.
// Depends on ico_pkg, ico_cordic, ico_isqrt and the defines header.
// Usage: one input beat (req_type, samples, timestamp) gives one result beat
// (angles, pose_valid, saturated). in_ready is high only when idle.
// A gyro beat passes ST_DT (dt product), then ST_GX, ST_GY and ST_GZ (one axis
// update each) before out_valid. Before the first accelerometer beat a gyro beat
// only stores its time and shows out_valid in the cycle after acceptance.
// An accelerometer beat runs ST_SQ for the squares, ST_SQRT for the 32 root
// steps, ST_CZ and ST_CX for the two 24-step CORDIC passes and, once the pose
// is set, the blend in ST_CX. A zero vector skips the CORDIC steps.
// out_valid holds with the result until out_ready; a stalled receiver holds
// the block, which accepts the next beat in the cycle after the result is taken.
// Write config only while no beat is in flight.
// Reset: theta zero, pose not valid, time zero, registers at reset values.
module imu_complementary_orientation_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic req_type,
	input  logic signed [15:0] sample_x,
	input  logic signed [15:0] sample_y,
	input  logic signed [15:0] sample_z,
	input  logic [31:0] timestamp,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] angle_x,
	output logic signed [31:0] angle_y,
	output logic signed [31:0] angle_z,
	output logic pose_valid,
	output logic saturated
);
	import ico_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_DT    = 10'b0000000010,
		ST_GX    = 10'b0000000100,
		ST_GY    = 10'b0000001000,
		ST_GZ    = 10'b0000010000,
		ST_SQ    = 10'b0000100000,
		ST_SQRT  = 10'b0001000000,
		ST_CZ    = 10'b0010000000,
		ST_CX    = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	state_t st_q;
	logic [15:0] alpha_q;
	logic [31:0] tick_q, last_q;
	logic await_q, sat_q, wait_q;
	logic signed [31:0] th_x_q, th_y_q, th_z_q, tilt_z_q;
	logic signed [15:0] sx_q, sy_q, sz_q;
	logic [31:0] ts_q;
	logic [46:0] p_q;
	logic [1:0] phase_q;
	logic [31:0] sumsq_q;

	// shared multiplier: up to 33x33 signed per cycle, one register after
	logic signed [32:0] ma, mb;
	logic signed [65:0] mp_q;
	logic [65:0] acc_q;

	cordic_req_t creq;
	logic c_busy, c_done, q_start, q_done;
	logic signed [31:0] c_angle;
	logic [31:0] q_root;

	ico_cordic u_cordic (.clk, .arst_n, .req(creq), .busy(c_busy), .done(c_done),
		.angle(c_angle));
	ico_isqrt u_isqrt (.clk, .arst_n, .start(q_start), .radicand(sumsq_q),
		.done(q_done), .root(q_root));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= AlphaReset;
			tick_q <= TickReset;
		end else if (cfg_we) begin
			if (cfg_index == RegAlpha) alpha_q <= cfg_data[15:0];
			else alpha_q <= alpha_q;
			if (cfg_index == RegTick) tick_q <= cfg_data;
		end
	end

	// gyro step helpers
	logic signed [15:0] rate;
	logic [15:0] mag;
	logic [62:0] prod;
	logic signed [48:0] stepv;
	logic signed [49:0] wide;
	logic signed [31:0] cur, clipped;
	logic clip_hit;

	always_comb begin
		case (st_q)
			ST_GX: begin rate = sz_q; cur = th_x_q; end
			ST_GY: begin rate = sy_q; cur = th_y_q; end
			default: begin rate = sx_q; cur = th_z_q; end
		endcase
		mag = rate[15] ? 16'(-rate) : rate;
		prod = 63'(mag) * 63'(p_q);
		stepv = rate[15] ? -49'(prod[62:15]) : 49'(prod[62:15]);
		if (st_q == ST_GZ) wide = 50'(cur) + 50'(stepv);
		else wide = 50'(cur) - 50'(stepv);
		clip_hit = 1'b0;
		if (wide > 50'sd2147483647) begin
			clipped = 32'sh7fffffff; clip_hit = 1'b1;
		end else if (wide < -50'sd2147483648) begin
			clipped = 32'sh80000000; clip_hit = 1'b1;
		end else begin
			clipped = wide[31:0];
		end
	end

	logic [31:0] dts;
	logic [63:0] pfull;
	assign dts = ts_q - last_q;
	assign pfull = 64'(dts) * 64'(tick_q);

	// blend: kept*alpha + tilt*(65536-alpha) + 32768, floor shift 16
	logic signed [31:0] bk, bt;
	logic signed [50:0] bsum;
	logic signed [31:0] bres;
	always_comb begin
		bk = (phase_q == 2'd0) ? th_z_q : th_x_q;
		bt = (phase_q == 2'd0) ? tilt_z_q : c_angle;
		ma = 33'(bk);
		mb = $signed({1'b0, alpha_q, 16'd0}) >>> 16;
		bsum = 51'(mp_q) + 51'(bt) * $signed({1'b0, 17'(18'h10000 - 18'(alpha_q))})
			+ 51'sd32768;
		bres = 32'(bsum >>> 16);
	end

	always_ff @(posedge clk) mp_q <= ma * mb;

	always_comb begin
		creq.start = 1'b0;
		creq.y = '0;
		creq.x = '0;
		if (st_q == ST_SQRT && q_done) begin
			creq.start = 1'b1;
			creq.y = 48'(sy_q) <<< 24;
			creq.x = 48'(sz_q) <<< 24;
		end else if (st_q == ST_CZ && c_done) begin
			creq.start = 1'b1;
			creq.y = 48'(sx_q) <<< 24;
			creq.x = 48'({q_root, 8'd0});
		end
	end

	assign q_start = (st_q == ST_SQ) && (phase_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			await_q <= 1'b1;
			last_q <= '0;
			th_x_q <= '0;
			th_y_q <= '0;
			th_z_q <= '0;
			sat_q <= 1'b0;
			phase_q <= '0;
			wait_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						sat_q <= 1'b0;
						phase_q <= '0;
						if (req_type == ReqGyro) st_q <= await_q ? ST_OUT : ST_DT;
						else st_q <= ST_SQ;
						if (req_type == ReqGyro) last_q <= await_q ? timestamp : last_q;
					end
				end
				ST_DT: begin
					last_q <= ts_q;
					st_q <= ST_GX;
				end
				ST_GX: begin
					th_x_q <= clipped; sat_q <= sat_q | clip_hit; st_q <= ST_GY;
				end
				ST_GY: begin
					th_y_q <= clipped; sat_q <= sat_q | clip_hit; st_q <= ST_GZ;
				end
				ST_GZ: begin
					th_z_q <= clipped; sat_q <= sat_q | clip_hit; st_q <= ST_OUT;
				end
				ST_SQ: begin
					phase_q <= phase_q + 2'd1;
					if (phase_q == 2'd2) st_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (q_done) st_q <= ST_CZ;
				end
				ST_CZ: begin
					if (c_done) st_q <= ST_CX;
					phase_q <= '0;
					wait_q <= 1'b0;
				end
				ST_CX: begin
					if (c_done && await_q) begin
						await_q <= 1'b0;
						th_x_q <= c_angle;
						th_y_q <= PiQ28;
						th_z_q <= tilt_z_q;
						st_q <= ST_OUT;
					end else if (c_done || wait_q) begin
						// blend z in phase 0; phase 1 registers the x product; blend x in phase 2
						if (!wait_q) begin
							wait_q <= 1'b1;
							phase_q <= '0;
						end else if (phase_q == 2'd0) begin
							th_z_q <= bres;
							phase_q <= 2'd1;
						end else if (phase_q == 2'd1) begin
							phase_q <= 2'd2;
						end else begin
							th_x_q <= bres;
							wait_q <= 1'b0;
							st_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (out_ready) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && in_valid) begin
			sx_q <= sample_x; sy_q <= sample_y; sz_q <= sample_z; ts_q <= timestamp;
		end
		if (st_q == ST_DT) begin
			p_q <= (pfull > 64'h00007fffffffffff) ? 47'h7fffffffffff : pfull[46:0];
		end
		if (st_q == ST_SQ) begin
			case (phase_q)
				2'd0: acc_q <= 66'(32'(sy_q) * 32'(sy_q));
				2'd1: sumsq_q <= 32'(acc_q) + 32'(sz_q) * 32'(sz_q);
				default: ;
			endcase
		end
		if (st_q == ST_CZ && c_done) tilt_z_q <= c_angle;
	end

	assign in_ready = (st_q == ST_IDLE);
	assign out_valid = (st_q == ST_OUT);
	assign angle_x = th_x_q;
	assign angle_y = th_y_q;
	assign angle_z = th_z_q;
	assign pose_valid = !await_q;
	assign saturated = sat_q;

	`include "imu_complementary_orientation_unit_defines.svh"
	`ICO_ASSERT_IMP(a_ready_idle, clk, arst_n, out_valid, !in_ready)
	`ICO_ASSERT_NXT(a_hold_out, clk, arst_n, out_valid && !out_ready, out_valid)
	`ICO_ASSERT_IMP(a_pose_sat, clk, arst_n, out_valid && !pose_valid, !saturated)
	`ICO_ASSERT_IMP(a_cordic_quiet, clk, arst_n, out_valid, !c_busy)
endmodule
